// ===== sv/jtl_pkg.sv =====
// Shared types and constants for the JSON token lexer.
// No dependencies; imported by json_token_lexer.
package jtl_pkg;

	localparam int INT_BITS_DEF = 32;
	localparam int MAX_RES      = 4;

	localparam logic [4:0] TK_LBRACK   = 5'd0;
	localparam logic [4:0] TK_RBRACK   = 5'd1;
	localparam logic [4:0] TK_LBRACE   = 5'd2;
	localparam logic [4:0] TK_RBRACE   = 5'd3;
	localparam logic [4:0] TK_COMMA    = 5'd4;
	localparam logic [4:0] TK_COLON    = 5'd5;
	localparam logic [4:0] TK_TRUE     = 5'd6;
	localparam logic [4:0] TK_STRBYTE  = 5'd9;
	localparam logic [4:0] TK_STREND   = 5'd10;
	localparam logic [4:0] TK_NUMCHAR  = 5'd11;
	localparam logic [4:0] TK_INTEND   = 5'd12;
	localparam logic [4:0] TK_FLOATEND = 5'd13;
	localparam logic [4:0] TK_EOF      = 5'd14;
	localparam logic [4:0] TK_ERROR    = 5'd15;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_BYTE    = 3'd1;
	localparam logic [2:0] ERR_KEYWORD = 3'd2;
	localparam logic [2:0] ERR_EXP     = 3'd3;
	localparam logic [2:0] ERR_HEX     = 3'd4;
	localparam logic [2:0] ERR_SURR    = 3'd5;
	localparam logic [2:0] ERR_EARLY   = 3'd6;

	typedef struct packed {
		logic [4:0]  kind;
		logic [7:0]  bval;
		logic [31:0] ival;
		logic [2:0]  err;
	} res_t;

	// expected character of keyword sel (true, false, null) after its first letter
	function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [1:0] pos);
		logic [7:0] c;
		c = 8'd0;
		unique case (sel)
			2'd0: c = (pos == 2'd0) ? "r" : (pos == 2'd1) ? "u" : (pos == 2'd2) ? "e" : 8'd0;
			2'd1: c = (pos == 2'd0) ? "a" : (pos == 2'd1) ? "l" : (pos == 2'd2) ? "s" : "e";
			default: c = (pos == 2'd0) ? "u" : (pos == 2'd1) ? "l" : (pos == 2'd2) ? "l" : 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] h;
		if (c >= "0" && c <= "9") h = {1'b0, 4'(c - "0")};
		else if (c >= "a" && c <= "f") h = {1'b0, 4'(c - "a" + 8'd10)};
		else if (c >= "A" && c <= "F") h = {1'b0, 4'(c - "A" + 8'd10)};
		else h = 5'h10;
		return h;
	endfunction

endpackage

// ===== sv/json_token_lexer.sv =====
// JSON token lexer top level: byte input stream, token event output stream.
// Depends on jtl_pkg.
//
// Usage:
//  s_axis_* carries one request per byte of JSON text: tdata is in_byte,
//  tuser is end_of_input (when set, tdata is ignored and the run is closed).
//  m_axis_* carries token events, one per transfer; tlast marks the final
//  event caused by one input byte.
//  Each accepted byte is lexed in the cycle it is taken; its 0 to 4 events
//  land in an 8-entry result queue and leave it one per cycle while
//  m_axis_tready is high; events are registered in the queue before they show.
//  Throughput: one byte per cycle while events drain as fast as they are
//  made; s_axis_tready is high whenever the queue has room for the four
//  events a byte can cause at most, so bytes that expand into several
//  events (unicode escapes, number ends) are paced by the output side.
//  When the receiver stalls, the queue fills and tready drops; nothing is
//  lost. Reset empties the queue, returns the lexer to idle, clears line,
//  column and any held error. Errors are sticky: after one, every byte
//  gives a single error event with the held code until reset.
module json_token_lexer
	import jtl_pkg::*;
#(
	parameter int INT_BITS = INT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte
	input  logic        s_axis_tuser,   // end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// token_kind[4:0], byte_value[12:5], int_value[44:13], error_code[47:45],
	// line_number[63:48], column_number[79:64]
	output logic [79:0] m_axis_tdata,
	output logic        m_axis_tlast    // last_of_run
);

	typedef enum logic [3:0] {
		M_IDLE, M_STRING, M_ESCAPE, M_UHEX, M_LOWBS, M_LOWU, M_LOWHEX,
		M_KEYWORD, M_INT, M_FRAC, M_EXPSTART, M_EXPSIGN, M_EXP, M_ERROR
	} mode_t;

	localparam int QD = 8;
	localparam logic [INT_BITS-1:0] LIM = {1'b1, {(INT_BITS-1){1'b0}}};

	mode_t               mode_q, mode_d;
	logic [1:0]          ksel_q, ksel_d, kpos_q, kpos_d;
	logic [15:0]         hacc_q, hacc_d;
	logic [2:0]          hcnt_q, hcnt_d;
	logic [9:0]          hsur_q, hsur_d;
	logic [INT_BITS-1:0] mag_q, mag_d;
	logic                neg_q, neg_d, ovf_q, ovf_d;
	logic [15:0]         line_q, line_d, col_q, col_d;
	logic [2:0]          herr_q, herr_d;

	res_t       res [MAX_RES];
	logic [2:0] nres;

	// result queue
	res_t       q_res_q  [QD];
	logic       q_last_q [QD];
	logic [15:0] q_line_q [QD];
	logic [15:0] q_col_q  [QD];
	logic [2:0] wr_q, rd_q;
	logic [3:0] cnt_q;

	logic acc, pop;
	assign s_axis_tready = (cnt_q <= 4'(QD - MAX_RES));
	assign acc = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (cnt_q != 4'd0);
	assign pop = m_axis_tvalid && m_axis_tready;

	logic [15:0] col_inc;
	assign col_inc = (col_q == 16'hFFFF) ? col_q : col_q + 16'd1;

	// value of the number so far, saturated to INT_BITS signed bits, low 32 bits
	function automatic logic [31:0] int_res(input logic [INT_BITS-1:0] m, input logic ng);
		logic [INT_BITS-1:0] v;
		logic [63:0]         w;
		if (ng) v = (m > LIM) ? (~LIM + 1'b1) : (~m + 1'b1);
		else    v = (m > LIM - 1'b1) ? (LIM - 1'b1) : m;
		w = 64'(signed'(v));
		return w[31:0];
	endfunction

	always_comb begin
		logic [7:0]  c;
		logic        dig, ise, fresh, hexdone, hexlow;
		logic [4:0]  h;
		logic [15:0] hn;
		logic [20:0] cp;
		logic        emit_cp;
		logic [INT_BITS+3:0] m10;
		logic [3:0]  d;
		mode_d = mode_q; ksel_d = ksel_q; kpos_d = kpos_q; hacc_d = hacc_q;
		hcnt_d = hcnt_q; hsur_d = hsur_q; mag_d = mag_q; neg_d = neg_q; ovf_d = ovf_q;
		line_d = line_q; col_d = col_q; herr_d = herr_q;
		nres = 3'd0;
		for (int i = 0; i < MAX_RES; i++) res[i] = '0;
		c = s_axis_tdata;
		dig = (c >= "0" && c <= "9");
		ise = (c == "e" || c == "E");
		d = 4'(c - "0");
		fresh = 1'b0; hexdone = 1'b0; hexlow = 1'b0; emit_cp = 1'b0; cp = '0;
		h = hex_val(c);
		hn = {hacc_q[11:0], h[3:0]};
		m10 = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + (INT_BITS+4)'(d);

		if (mode_q == M_ERROR) begin
			res[0] = '{TK_ERROR, 8'd0, 32'd0, herr_q}; nres = 3'd1;
		end else if (s_axis_tuser) begin
			unique case (mode_q)
				M_IDLE: begin
					res[0] = '{TK_EOF, 8'd0, 32'd0, ERR_NONE}; nres = 3'd1;
				end
				M_INT: begin
					res[0] = '{TK_INTEND, 8'd0, int_res(mag_q, neg_q), ERR_NONE};
					res[1] = '{TK_EOF, 8'd0, 32'd0, ERR_NONE}; nres = 3'd2; mode_d = M_IDLE;
				end
				M_FRAC, M_EXP: begin
					res[0] = '{TK_FLOATEND, 8'd0, 32'd0, ERR_NONE};
					res[1] = '{TK_EOF, 8'd0, 32'd0, ERR_NONE}; nres = 3'd2; mode_d = M_IDLE;
				end
				default: begin
					res[0] = '{TK_ERROR, 8'd0, 32'd0, ERR_EARLY}; nres = 3'd1;
					herr_d = ERR_EARLY; mode_d = M_ERROR;
				end
			endcase
		end else begin
			col_d = col_inc;
			unique case (mode_q)
				M_STRING: begin
					if (c == "\"") begin
						res[0] = '{TK_STREND, 8'd0, 32'd0, ERR_NONE}; nres = 3'd1; mode_d = M_IDLE;
					end else if (c == "\\") mode_d = M_ESCAPE;
					else begin
						res[0] = '{TK_STRBYTE, c, 32'd0, ERR_NONE}; nres = 3'd1;
					end
				end
				M_ESCAPE: begin
					mode_d = M_STRING; nres = 3'd1;
					priority case (c)
						"\"", "\\", "/": res[0] = '{TK_STRBYTE, c, 32'd0, ERR_NONE};
						"b": res[0] = '{TK_STRBYTE, 8'h08, 32'd0, ERR_NONE};
						"f": res[0] = '{TK_STRBYTE, 8'h0C, 32'd0, ERR_NONE};
						"n": res[0] = '{TK_STRBYTE, 8'h0A, 32'd0, ERR_NONE};
						"r": res[0] = '{TK_STRBYTE, 8'h0D, 32'd0, ERR_NONE};
						"t": res[0] = '{TK_STRBYTE, 8'h09, 32'd0, ERR_NONE};
						"u": begin
							nres = 3'd0; hacc_d = '0; hcnt_d = '0; mode_d = M_UHEX;
						end
						default: begin
							res[0] = '{TK_STRBYTE, "\\", 32'd0, ERR_NONE};
							res[1] = '{TK_STRBYTE, c, 32'd0, ERR_NONE}; nres = 3'd2;
						end
					endcase
				end
				M_UHEX, M_LOWHEX: begin
					hexlow = (mode_q == M_LOWHEX);
					if (h[4]) begin
						res[0] = '{TK_ERROR, 8'd0, 32'd0, ERR_HEX}; nres = 3'd1;
						herr_d = ERR_HEX; mode_d = M_ERROR;
					end else begin
						hacc_d = hn; hcnt_d = hcnt_q + 3'd1;
						hexdone = (hcnt_q + 3'd1 >= 3'd4);
					end
				end
				M_LOWBS: begin
					if (c == "\\") mode_d = M_LOWU;
					else begin
						res[0] = '{TK_ERROR, 8'd0, 32'd0, ERR_SURR}; nres = 3'd1;
						herr_d = ERR_SURR; mode_d = M_ERROR;
					end
				end
				M_LOWU: begin
					if (c == "u") begin
						hacc_d = '0; hcnt_d = '0; mode_d = M_LOWHEX;
					end else begin
						res[0] = '{TK_ERROR, 8'd0, 32'd0, ERR_SURR}; nres = 3'd1;
						herr_d = ERR_SURR; mode_d = M_ERROR;
					end
				end
				M_KEYWORD: begin
					logic [1:0] sel;
					sel = (ksel_q == 2'd3) ? 2'd2 : ksel_q;
					if (c != kw_char(sel, kpos_q)) begin
						res[0] = '{TK_ERROR, 8'd0, 32'd0, ERR_KEYWORD}; nres = 3'd1;
						herr_d = ERR_KEYWORD; mode_d = M_ERROR;
					end else if ({1'b0, kpos_q} + 3'd1 >= ((sel == 2'd1) ? 3'd4 : 3'd3)) begin
						res[0] = '{TK_TRUE + 5'(sel), 8'd0, 32'd0, ERR_NONE}; nres = 3'd1;
						mode_d = M_IDLE;
					end else kpos_d = kpos_q + 2'd1;
				end
				M_INT: begin
					if (dig) begin
						if (m10 > (INT_BITS+4)'(LIM)) begin
							mag_d = LIM; ovf_d = 1'b1;
						end else mag_d = m10[INT_BITS-1:0];
						res[0] = '{TK_NUMCHAR, c, 32'd0, ERR_NONE}; nres = 3'd1;
					end else if (c == ".") begin
						res[0] = '{TK_NUMCHAR, c, 32'd0, ERR_NONE}; nres = 3'd1; mode_d = M_FRAC;
					end else if (ise) begin
						res[0] = '{TK_NUMCHAR, c, 32'd0, ERR_NONE}; nres = 3'd1;
						mode_d = M_EXPSTART;
					end else begin
						res[0] = '{TK_INTEND, 8'd0, int_res(mag_q, neg_q), ERR_NONE};
						nres = 3'd1; fresh = 1'b1;
					end
				end
				M_FRAC: begin
					if (dig) begin
						res[0] = '{TK_NUMCHAR, c, 32'd0, ERR_NONE}; nres = 3'd1;
					end else if (ise) begin
						res[0] = '{TK_NUMCHAR, c, 32'd0, ERR_NONE}; nres = 3'd1;
						mode_d = M_EXPSTART;
					end else begin
						res[0] = '{TK_FLOATEND, 8'd0, 32'd0, ERR_NONE}; nres = 3'd1; fresh = 1'b1;
					end
				end
				M_EXPSTART, M_EXPSIGN: begin
					if ((c == "-" || c == "+") && mode_q == M_EXPSTART) begin
						res[0] = '{TK_NUMCHAR, c, 32'd0, ERR_NONE}; nres = 3'd1; mode_d = M_EXPSIGN;
					end else if (dig) begin
						res[0] = '{TK_NUMCHAR, c, 32'd0, ERR_NONE}; nres = 3'd1; mode_d = M_EXP;
					end else begin
						res[0] = '{TK_ERROR, 8'd0, 32'd0, ERR_EXP}; nres = 3'd1;
						herr_d = ERR_EXP; mode_d = M_ERROR;
					end
				end
				M_EXP: begin
					if (dig) begin
						res[0] = '{TK_NUMCHAR, c, 32'd0, ERR_NONE}; nres = 3'd1;
					end else begin
						res[0] = '{TK_FLOATEND, 8'd0, 32'd0, ERR_NONE}; nres = 3'd1; fresh = 1'b1;
					end
				end
				default: fresh = 1'b1;
			endcase

			// byte seen from idle, possibly right after a number end
			if (fresh) begin
				mode_d = M_IDLE;
				priority case (c)
					8'h0A: begin
						if (line_q != 16'hFFFF) line_d = line_q + 16'd1;
						col_d = 16'd0;
					end
					" ", 8'h09, 8'h0D: ;
					"[": begin res[nres[1:0]] = '{TK_LBRACK, 8'd0, 32'd0, ERR_NONE}; nres++; end
					"]": begin res[nres[1:0]] = '{TK_RBRACK, 8'd0, 32'd0, ERR_NONE}; nres++; end
					"{": begin res[nres[1:0]] = '{TK_LBRACE, 8'd0, 32'd0, ERR_NONE}; nres++; end
					"}": begin res[nres[1:0]] = '{TK_RBRACE, 8'd0, 32'd0, ERR_NONE}; nres++; end
					",": begin res[nres[1:0]] = '{TK_COMMA, 8'd0, 32'd0, ERR_NONE}; nres++; end
					":": begin res[nres[1:0]] = '{TK_COLON, 8'd0, 32'd0, ERR_NONE}; nres++; end
					"\"": mode_d = M_STRING;
					"t": begin ksel_d = 2'd0; kpos_d = 2'd0; mode_d = M_KEYWORD; end
					"f": begin ksel_d = 2'd1; kpos_d = 2'd0; mode_d = M_KEYWORD; end
					"n": begin ksel_d = 2'd2; kpos_d = 2'd0; mode_d = M_KEYWORD; end
					default: begin
						if (c == "-" || dig) begin
							neg_d = (c == "-");
							mag_d = (c == "-") ? '0 : INT_BITS'(d);
							ovf_d = 1'b0;
							res[nres[1:0]] = '{TK_NUMCHAR, c, 32'd0, ERR_NONE}; nres++;
							mode_d = M_INT;
						end else begin
							res[nres[1:0]] = '{TK_ERROR, 8'd0, 32'd0, ERR_BYTE}; nres++;
							herr_d = ERR_BYTE; mode_d = M_ERROR;
						end
					end
				endcase
			end

			// fourth hex digit: pick the code point, wait for the low half, or flag a bad low half
			if (hexdone) begin
				mode_d = M_STRING;
				if (!hexlow) begin
					if (hn >= 16'hD800 && hn <= 16'hDBFF) begin
						hsur_d = 10'(hn - 16'hD800); mode_d = M_LOWBS;
					end else begin
						cp = 21'(hn); emit_cp = 1'b1;
					end
				end else if (hn < 16'hDC00 || hn > 16'hDFFF) begin
					res[0] = '{TK_ERROR, 8'd0, 32'd0, ERR_SURR}; nres = 3'd1;
					herr_d = ERR_SURR; mode_d = M_ERROR;
				end else begin
					cp = (21'(hsur_q) << 10) + 21'(hn - 16'hDC00) + 21'h10000;
					emit_cp = 1'b1;
				end
			end
			if (emit_cp) begin
				if (cp <= 21'h7F) begin
					res[0] = '{TK_STRBYTE, cp[7:0], 32'd0, ERR_NONE}; nres = 3'd1;
				end else if (cp <= 21'h7FF) begin
					res[0] = '{TK_STRBYTE, {3'b110, cp[10:6]}, 32'd0, ERR_NONE};
					res[1] = '{TK_STRBYTE, {2'b10, cp[5:0]}, 32'd0, ERR_NONE}; nres = 3'd2;
				end else if (cp <= 21'hFFFF) begin
					res[0] = '{TK_STRBYTE, {4'b1110, cp[15:12]}, 32'd0, ERR_NONE};
					res[1] = '{TK_STRBYTE, {2'b10, cp[11:6]}, 32'd0, ERR_NONE};
					res[2] = '{TK_STRBYTE, {2'b10, cp[5:0]}, 32'd0, ERR_NONE}; nres = 3'd3;
				end else begin
					res[0] = '{TK_STRBYTE, {5'b11110, cp[20:18]}, 32'd0, ERR_NONE};
					res[1] = '{TK_STRBYTE, {2'b10, cp[17:12]}, 32'd0, ERR_NONE};
					res[2] = '{TK_STRBYTE, {2'b10, cp[11:6]}, 32'd0, ERR_NONE};
					res[3] = '{TK_STRBYTE, {2'b10, cp[5:0]}, 32'd0, ERR_NONE}; nres = 3'd4;
				end
			end
		end
	end

	// lexer state: advance only on an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; ksel_q <= '0; kpos_q <= '0; hacc_q <= '0; hcnt_q <= '0;
			hsur_q <= '0; mag_q <= '0; neg_q <= 1'b0; ovf_q <= 1'b0;
			line_q <= '0; col_q <= '0; herr_q <= ERR_NONE;
		end else if (acc) begin
			mode_q <= mode_d; ksel_q <= ksel_d; kpos_q <= kpos_d; hacc_q <= hacc_d;
			hcnt_q <= hcnt_d; hsur_q <= hsur_d; mag_q <= mag_d; neg_q <= neg_d;
			ovf_q <= ovf_d; line_q <= line_d; col_q <= col_d; herr_q <= herr_d;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (acc) wr_q <= wr_q + nres;
			if (pop) rd_q <= rd_q + 3'd1;
			cnt_q <= cnt_q + (acc ? {1'b0, nres} : 4'd0) - (pop ? 4'd1 : 4'd0);
		end
	end

	// queue payload: drop the events of one byte in at consecutive slots
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (3'(i) < nres) begin
					q_res_q[wr_q + 3'(i)]  <= res[i];
					q_last_q[wr_q + 3'(i)] <= (3'(i) == nres - 3'd1);
					q_line_q[wr_q + 3'(i)] <= line_q;
					q_col_q[wr_q + 3'(i)]  <= (mode_q == M_ERROR || s_axis_tuser) ? col_q : col_inc;
				end
			end
		end
	end

	assign m_axis_tdata = {q_col_q[rd_q], q_line_q[rd_q], q_res_q[rd_q].err,
		q_res_q[rd_q].ival, q_res_q[rd_q].bval, q_res_q[rd_q].kind};
	assign m_axis_tlast = q_last_q[rd_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 4'(QD))
		else $error("result queue overfilled");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !pop) |=> cnt_q == $past(cnt_q) + {1'b0, $past(nres)})
		else $error("queue count lost events");
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_ERROR) |=> mode_q == M_ERROR)
		else $error("error state left without reset");

endmodule
